>>> rtl/ffra_pkg.sv
// Shared types and constants for the first-fit region allocator.
// Payload structs, command and status codes and sequencer states; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

   localparam int ADDR_WIDTH  = 20;
   localparam int SIZE_WIDTH  = 16;
   localparam int CMD_WIDTH   = 2;
   localparam int STAT_WIDTH  = 3;
   localparam int MAX_REGIONS = 16;

   localparam logic [CMD_WIDTH-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_REALLOC = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_RECLAIM = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_REWIND  = 2'd3;

   localparam logic [STAT_WIDTH-1:0] ST_OK          = 3'd0;
   localparam logic [STAT_WIDTH-1:0] ST_UNKNOWN     = 3'd1;
   localparam logic [STAT_WIDTH-1:0] ST_TABLE_FULL  = 3'd2;
   localparam logic [STAT_WIDTH-1:0] ST_POOL_EMPTY  = 3'd3;
   localparam logic [STAT_WIDTH-1:0] ST_BAD_REALLOC = 3'd4;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  cmd;
      logic [SIZE_WIDTH-1:0] req_bytes;
      logic [ADDR_WIDTH-1:0] handle;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] base_addr;
      logic [ADDR_WIDTH-1:0] copy_from;
      logic [SIZE_WIDTH-1:0] copy_len;
      logic [STAT_WIDTH-1:0] status;
   } rsp_item_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_GRANT,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

>>> rtl/ffra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the region base and capacity tables; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ffra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/first_fit_region_allocator.sv
// First-fit region allocator: top level with sequencer and region tables.
// Depends on ffra_pkg and ffra_ram.
//
// Usage:
//  - req channel (req_valid/req_stall/req_item) carries one command per item:
//    alloc, realloc, reclaim or rewind. rsp channel returns exactly one item
//    per command with base, copy source, copy length and status.
//  - Commands are handled one at a time; req_stall is high while a command is
//    being worked on. A finished result sits in the output register, and the
//    next command is taken while it waits there.
//  - Alloc, reclaim and realloc scan the table through the read ports of the
//    base and capacity RAMs, one entry per cycle. Alloc runs a grant scan,
//    reclaim a lookup scan, and realloc a lookup scan and then a grant scan.
//    Rewind clears the active bits without a scan.
//  - Reset clears the active bits, the region count and the bump pointer.
//    The base and capacity tables are not cleared; only appended entries
//    are ever read.
//  - While rsp_stall is high the result holds; a finished next command waits
//    in its done state until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_region_allocator #(
   parameter int MAX_REGIONS = ffra_pkg::MAX_REGIONS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire ffra_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output ffra_pkg::rsp_item_type      rsp_item
);

   localparam int AW    = ffra_pkg::ADDR_WIDTH;
   localparam int SW    = ffra_pkg::SIZE_WIDTH;
   localparam int IW    = $clog2(MAX_REGIONS);
   localparam int CW    = $clog2(MAX_REGIONS + 1);
   localparam int SUM_W = ((AW + 1 > SW) ? AW + 1 : SW) + 1;

   localparam logic [SUM_W-1:0] POOL_LIMIT = SUM_W'(1) << AW;

   ffra_pkg::state_type state_ff, state_in;

   logic [ffra_pkg::CMD_WIDTH-1:0] cmd_ff, cmd_in;
   logic [SW-1:0]                  req_ff, req_in;
   logic [AW-1:0]                  handle_ff, handle_in;

   logic [CW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   pend_ff, pend_in;
   logic [IW-1:0]          pend_idx_ff, pend_idx_in;
   logic [IW-1:0]          fidx_ff, fidx_in;
   logic [SW-1:0]          fcap_ff, fcap_in;
   logic [MAX_REGIONS-1:0] active_ff, active_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW:0]            bump_ff, bump_in;

   ffra_pkg::rsp_item_type res_ff, res_in;
   ffra_pkg::rsp_item_type rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic          ram_we;
   logic [AW-1:0] base_rd;
   logic [SW-1:0] cap_rd;

   logic             req_take, rsp_free;
   logic             more, find_hit, grant_hit, hit, scan_miss, issue;
   logic             realloc_ok, table_full, pool_ok;
   logic [SUM_W-1:0] sum;

   // Region tables: written on append at count_ff, read at the scan pointer
   ffra_ram #(
      .WIDTH(AW),
      .DEPTH(MAX_REGIONS)
   ) u_base_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff[IW-1:0]),
      .wr_data(bump_ff[AW-1:0]),
      .rd_addr(rd_idx_ff[IW-1:0]),
      .rd_data(base_rd)
   );

   ffra_ram #(
      .WIDTH(SW),
      .DEPTH(MAX_REGIONS)
   ) u_cap_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff[IW-1:0]),
      .wr_data(req_ff),
      .rd_addr(rd_idx_ff[IW-1:0]),
      .rd_data(cap_rd)
   );

   // Scan and compare logic shared by the lookup and grant passes
   always_comb begin
      req_take   = req_valid && (state_ff == ffra_pkg::S_IDLE);
      rsp_free   = !rsp_valid_ff || !rsp_stall;
      more       = rd_idx_ff < count_ff;
      find_hit   = pend_ff && (base_rd == handle_ff);
      grant_hit  = pend_ff && !active_ff[pend_idx_ff] && (cap_rd >= req_ff);
      hit        = (state_ff == ffra_pkg::S_FIND) ? find_hit : grant_hit;
      scan_miss  = !pend_ff && !more;
      issue      = more && !hit;
      realloc_ok = active_ff[pend_idx_ff] && (cap_rd <= req_ff);
      table_full = count_ff == CW'(MAX_REGIONS);
      sum        = SUM_W'(bump_ff) + SUM_W'(req_ff);
      pool_ok    = sum <= POOL_LIMIT;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffra_pkg::S_IDLE: begin
            if (req_valid) begin
               case (req_item.cmd)
                  ffra_pkg::CMD_REWIND: state_in = ffra_pkg::S_DONE;
                  ffra_pkg::CMD_ALLOC:  state_in = ffra_pkg::S_GRANT;
                  default:              state_in = ffra_pkg::S_FIND;
               endcase
            end
         end
         ffra_pkg::S_FIND: begin
            if (find_hit) begin
               if (cmd_ff == ffra_pkg::CMD_REALLOC && realloc_ok) begin
                  state_in = ffra_pkg::S_GRANT;
               end else begin
                  state_in = ffra_pkg::S_DONE;
               end
            end else if (scan_miss) begin
               state_in = ffra_pkg::S_DONE;
            end
         end
         ffra_pkg::S_GRANT: begin
            if (grant_hit || scan_miss) begin
               state_in = ffra_pkg::S_DONE;
            end
         end
         ffra_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = ffra_pkg::S_IDLE;
            end
         end
         default: state_in = ffra_pkg::S_IDLE;
      endcase
   end

   // Datapath and table updates
   always_comb begin
      cmd_in       = cmd_ff;
      req_in       = req_ff;
      handle_in    = handle_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      fidx_in      = fidx_ff;
      fcap_in      = fcap_ff;
      active_in    = active_ff;
      count_in     = count_ff;
      bump_in      = bump_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;

      case (state_ff)
         ffra_pkg::S_IDLE: begin
            if (req_take) begin
               cmd_in    = req_item.cmd;
               req_in    = req_item.req_bytes;
               handle_in = req_item.handle;
               rd_idx_in = '0;
               res_in    = '0;
               if (req_item.cmd == ffra_pkg::CMD_REWIND) begin
                  active_in = '0;
               end
            end
         end
         ffra_pkg::S_FIND: begin
            pend_in     = issue;
            pend_idx_in = rd_idx_ff[IW-1:0];
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (find_hit) begin
               fidx_in = pend_idx_ff;
               fcap_in = cap_rd;
               if (cmd_ff == ffra_pkg::CMD_RECLAIM) begin
                  active_in[pend_idx_ff] = 1'b0;
               end else if (realloc_ok) begin
                  // free the old region, then rescan from the top
                  active_in[pend_idx_ff] = 1'b0;
                  rd_idx_in = '0;
                  pend_in   = 1'b0;
               end else begin
                  res_in.status = ffra_pkg::ST_BAD_REALLOC;
               end
            end else if (scan_miss) begin
               res_in.status = ffra_pkg::ST_UNKNOWN;
            end
         end
         ffra_pkg::S_GRANT: begin
            pend_in     = issue;
            pend_idx_in = rd_idx_ff[IW-1:0];
            if (issue) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            if (grant_hit) begin
               active_in[pend_idx_ff] = 1'b1;
               res_in.base_addr = base_rd;
               if (cmd_ff == ffra_pkg::CMD_REALLOC) begin
                  res_in.copy_from = handle_ff;
                  res_in.copy_len  = fcap_ff;
               end
            end else if (scan_miss) begin
               if (table_full || !pool_ok) begin
                  res_in.status = table_full ? ffra_pkg::ST_TABLE_FULL
                                             : ffra_pkg::ST_POOL_EMPTY;
                  if (cmd_ff == ffra_pkg::CMD_REALLOC) begin
                     active_in[fidx_ff] = 1'b1;
                  end
               end else begin
                  // append a new region at the bump pointer
                  ram_we = 1'b1;
                  active_in[count_ff[IW-1:0]] = 1'b1;
                  count_in = count_ff + CW'(1);
                  bump_in  = sum[AW:0];
                  res_in.base_addr = bump_ff[AW-1:0];
                  if (cmd_ff == ffra_pkg::CMD_REALLOC) begin
                     res_in.copy_from = handle_ff;
                     res_in.copy_len  = fcap_ff;
                  end
               end
            end
         end
         ffra_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffra_pkg::S_IDLE;
         pend_ff      <= 1'b0;
         active_ff    <= '0;
         count_ff     <= '0;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         active_ff    <= active_in;
         count_ff     <= count_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      req_ff      <= req_in;
      handle_ff   <= handle_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      fidx_ff     <= fidx_in;
      fcap_ff     <= fcap_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ffra_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_REGIONS))
      else $error("region count beyond table depth");

   a_bump_range: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= {1'b1, {AW{1'b0}}})
      else $error("bump pointer beyond pool");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ffra_pkg::S_IDLE)
      else $error("accepted item left no work");

   a_append_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ffra_pkg::S_GRANT && !table_full && pool_ok)
      else $error("table append outside a grant miss");

endmodule

`default_nettype wire

>>> tb/tb_first_fit_region_allocator.sv
// Self-checking testbench for first_fit_region_allocator: directed table then random commands.
// Uses ffra_pkg for payload types, command and status codes; needs only the RTL.
`timescale 1ns / 1ps

module tb_first_fit_region_allocator;

   localparam int AW           = ffra_pkg::ADDR_WIDTH;
   localparam int SW           = ffra_pkg::SIZE_WIDTH;
   localparam int STW          = ffra_pkg::STAT_WIDTH;
   localparam int CMW          = ffra_pkg::CMD_WIDTH;
   localparam int NREG         = ffra_pkg::MAX_REGIONS;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int DRAIN_CYCLES = 50;

   typedef struct {
      ffra_pkg::req_item_type item;
      bit                     fixed;
      ffra_pkg::rsp_item_type want;
   } dir_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   ffra_pkg::req_item_type req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   ffra_pkg::rsp_item_type rsp_item;

   // allocator shadow: region table, count and bump pointer
   logic [AW-1:0] tbl_base [NREG];
   logic [SW-1:0] tbl_cap  [NREG];
   bit            tbl_active [NREG];
   int            tbl_count = 0;
   logic [AW:0]   tbl_bump  = '0;

   ffra_pkg::rsp_item_type pending_rsp[$];
   bit  idle_on        = 1'b1;
   int  stall_left     = 0;
   int  fail_count     = 0;
   int  results_checked = 0;
   int  full_seen      = 0;
   int  cmd_seen[4]    = '{0, 0, 0, 0};
   int  cycle_count    = 0;

   first_fit_region_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #1 clock = ~clock;

   function automatic logic [STW-1:0] grant_region(input logic [SW-1:0] bytes,
                                                   output logic [AW-1:0] base);
      int i;
      base = '0;
      for (i = 0; i < tbl_count; i++) begin
         if (!tbl_active[i] && tbl_cap[i] >= bytes) begin
            tbl_active[i] = 1'b1;
            base = tbl_base[i];
            return ffra_pkg::ST_OK;
         end
      end
      if (tbl_count >= NREG)
         return ffra_pkg::ST_TABLE_FULL;
      if (longint'(tbl_bump) + longint'(bytes) > (longint'(1) << AW))
         return ffra_pkg::ST_POOL_EMPTY;
      tbl_base[tbl_count]   = tbl_bump[AW-1:0];
      tbl_cap[tbl_count]    = bytes;
      tbl_active[tbl_count] = 1'b1;
      base = tbl_bump[AW-1:0];
      tbl_count++;
      tbl_bump = tbl_bump + (AW + 1)'(bytes);
      return ffra_pkg::ST_OK;
   endfunction

   // first region in table order whose base matches
   function automatic int region_of(input logic [AW-1:0] handle);
      int i;
      for (i = 0; i < tbl_count; i++)
         if (tbl_base[i] == handle)
            return i;
      return -1;
   endfunction

   function automatic ffra_pkg::rsp_item_type predict_allocator(
         input ffra_pkg::req_item_type it);
      ffra_pkg::rsp_item_type r;
      int                     idx;
      int                     i;
      logic [AW-1:0]          b;
      r = '0;
      case (it.cmd)
         ffra_pkg::CMD_ALLOC: begin
            r.status    = grant_region(it.req_bytes, b);
            r.base_addr = b;
         end
         ffra_pkg::CMD_REALLOC: begin
            idx = region_of(it.handle);
            if (idx < 0) begin
               r.status = ffra_pkg::ST_UNKNOWN;
            end else if (!tbl_active[idx] || tbl_cap[idx] > it.req_bytes) begin
               r.status = ffra_pkg::ST_BAD_REALLOC;
            end else begin
               tbl_active[idx] = 1'b0;
               r.status = grant_region(it.req_bytes, b);
               if (r.status == ffra_pkg::ST_OK) begin
                  r.base_addr = b;
                  r.copy_from = tbl_base[idx];
                  r.copy_len  = tbl_cap[idx];
               end else begin
                  tbl_active[idx] = 1'b1;
               end
            end
         end
         ffra_pkg::CMD_RECLAIM: begin
            idx = region_of(it.handle);
            if (idx < 0)
               r.status = ffra_pkg::ST_UNKNOWN;
            else
               tbl_active[idx] = 1'b0;
         end
         default: begin
            for (i = 0; i < NREG; i++)
               tbl_active[i] = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic dir_row_type row(input logic [CMW-1:0] c,
                                       input logic [SW-1:0] bytes,
                                       input logic [AW-1:0] handle,
                                       input bit fixed,
                                       input logic [AW-1:0] base,
                                       input logic [STW-1:0] st);
      dir_row_type d;
      d.item.cmd       = c;
      d.item.req_bytes = bytes;
      d.item.handle    = handle;
      d.fixed          = fixed;
      d.want           = '0;
      d.want.base_addr = base;
      d.want.status    = st;
      return d;
   endfunction

   // favor active regions so realloc gets past the lookup
   function automatic int pick_region();
      int act[$];
      int i;
      if (tbl_count == 0)
         return -1;
      for (i = 0; i < tbl_count; i++)
         if (tbl_active[i])
            act.push_back(i);
      if (act.size() > 0 && $urandom_range(0, 3) != 0)
         return act[$urandom_range(0, act.size() - 1)];
      return int'($urandom_range(0, tbl_count - 1));
   endfunction

   function automatic logic [SW-1:0] pick_size();
      int k;
      int t;
      k = pick_region();
      case ($urandom_range(0, 3))
         0: return SW'($urandom_range(0, 64));
         1: return SW'($urandom);
         2: return (k < 0) ? SW'($urandom) : tbl_cap[k];
         default: begin
            if (k < 0)
               return SW'($urandom);
            t = int'(tbl_cap[k]) + int'($urandom_range(0, 3));
            return (t > 65535) ? 16'hFFFF : t[SW-1:0];
         end
      endcase
   endfunction

   function automatic ffra_pkg::req_item_type random_command();
      ffra_pkg::req_item_type it;
      int pick;
      int k;
      int t;
      it.cmd       = ffra_pkg::CMD_ALLOC;
      it.req_bytes = SW'($urandom);
      it.handle    = AW'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // noise: any command, any size, mostly unknown handles
         it.cmd = CMW'($urandom);
      end else if (pick < 45) begin
         it.cmd       = ffra_pkg::CMD_ALLOC;
         it.req_bytes = pick_size();
      end else if (pick < 70) begin
         it.cmd = ffra_pkg::CMD_REALLOC;
         k = pick_region();
         if (k >= 0) begin
            it.handle = tbl_base[k];
            if ($urandom_range(0, 4) != 0) begin
               t = int'(tbl_cap[k]) + int'($urandom_range(0, 500));
               it.req_bytes = (t > 65535) ? 16'hFFFF : t[SW-1:0];
            end else if (tbl_cap[k] != 0) begin
               it.req_bytes = tbl_cap[k] - SW'(1);
            end
         end
      end else if (pick < 97) begin
         it.cmd = ffra_pkg::CMD_RECLAIM;
         k = pick_region();
         if (k >= 0)
            it.handle = tbl_base[k];
      end else begin
         it.cmd = ffra_pkg::CMD_REWIND;
      end
      return it;
   endfunction

   task automatic send(input ffra_pkg::req_item_type it, input bit fixed,
                       input ffra_pkg::rsp_item_type want);
      int                     gap;
      ffra_pkg::rsp_item_type got;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      got = predict_allocator(it);
      pending_rsp.push_back(fixed ? want : got);
      cmd_seen[it.cmd]++;
   endtask

   // result side: check each accepted item, then draw the next stall
   always @(posedge clock) begin : rsp_side
      ffra_pkg::rsp_item_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected result item: base_addr %0h status %0d",
                      rsp_item.base_addr, rsp_item.status);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_item.base_addr !== want.base_addr) begin
                  $error("base_addr: expected %0h, got %0h", want.base_addr, rsp_item.base_addr);
                  fail_count++;
               end
               if (rsp_item.copy_from !== want.copy_from) begin
                  $error("copy_from: expected %0h, got %0h", want.copy_from, rsp_item.copy_from);
                  fail_count++;
               end
               if (rsp_item.copy_len !== want.copy_len) begin
                  $error("copy_len: expected %0h, got %0h", want.copy_len, rsp_item.copy_len);
                  fail_count++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_item.status);
                  fail_count++;
               end
               if (want.status == ffra_pkg::ST_TABLE_FULL)
                  full_seen++;
               results_checked++;
            end
            stall_left = idle_on ? $urandom_range(0, 12) : 0;
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      dir_row_type rows[$];
      int          i;
      // empty table, lookups, zero-byte regions sharing base 0, first-match handle
      rows.push_back(row(ffra_pkg::CMD_RECLAIM, 16'd0, 20'd0,
                         1, 20'd0, ffra_pkg::ST_UNKNOWN));
      rows.push_back(row(ffra_pkg::CMD_REALLOC, 16'hFFFF, 20'hFFFFF,
                         1, 20'd0, ffra_pkg::ST_UNKNOWN));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd0, 20'd0,
                         1, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd0, 20'hFFFFF,
                         1, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd100, 20'd0,
                         1, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_RECLAIM, 16'd0, 20'd0,
                         1, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_REALLOC, 16'd50, 20'd0,
                         1, 20'd0, ffra_pkg::ST_BAD_REALLOC));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd10, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      // shrink refused, same size lands in place, growth appends
      rows.push_back(row(ffra_pkg::CMD_REALLOC, 16'd5, 20'd100,
                         1, 20'd0, ffra_pkg::ST_BAD_REALLOC));
      rows.push_back(row(ffra_pkg::CMD_REALLOC, 16'd10, 20'd100,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_REALLOC, 16'hFFFF, 20'd100,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd0, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      // fill the table; the pool cannot run dry before the table does
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd1, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'h8000, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'hFFFF, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd7, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd300, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd4096, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd20, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'hFFFF, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd1000, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd50, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd2, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'd3, 20'd0,
                         0, 20'd0, ffra_pkg::ST_OK));
      rows.push_back(row(ffra_pkg::CMD_ALLOC, 16'hFFFF, 20'd0,
                         1, 20'd0, ffra_pkg::ST_TABLE_FULL));
      rows.push_back(row(ffra_pkg::CMD_REWIND, 16'hFFFF, 20'hFFFFF,
                         1, 20'd0, ffra_pkg::ST_OK));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < rows.size(); i++)
         send(rows[i].item, rows[i].fixed, rows[i].want);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         idle_on = !(i >= 300 && i < 500);
         // hold off until the pipe is empty once; drop valid so nothing repeats
         if (i == 800) begin
            req_valid <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         send(random_command(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d alloc, %0d realloc, %0d reclaim, %0d rewind commands.",
               results_checked, cmd_seen[ffra_pkg::CMD_ALLOC], cmd_seen[ffra_pkg::CMD_REALLOC],
               cmd_seen[ffra_pkg::CMD_RECLAIM], cmd_seen[ffra_pkg::CMD_REWIND]);
      $display("Table-full refusals: %0d; random stalls on both sides plus a stall-free stretch.",
               full_seen);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
